// ===== rtl/core/cba_pkg.sv =====
// Shared types and constants for the contiguous block allocator.
`timescale 1ns / 1ps

package cba_pkg;

  localparam int NAME_W   = 8;
  localparam int LEN_W    = 6;
  localparam int STATUS_W = 3;
  localparam int START_W  = 5;
  localparam int DATA_W   = 16;

  localparam logic [STATUS_W-1:0] ST_CREATED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOSPACE  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DELETED  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BADLEN   = 3'd4;

  localparam logic FUNC_CREATE = 1'b0;

  typedef enum logic [1:0] {
    OP_CREATE,
    OP_DELETE,
    OP_BADLEN,
    OP_NOSPACE
  } op_t;

  typedef struct packed {
    op_t               kind;
    logic [NAME_W-1:0] file_name;
    logic [LEN_W-1:0]  block_count;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [START_W-1:0]  start_block;
    logic [LEN_W-1:0]    run_length;
  } res_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_ALLOC,
    BK_MARK,
    BK_DEL,
    BK_FREE,
    BK_REPLY
  } bk_state_t;

endpackage

// ===== rtl/core/contiguous_block_allocator.sv =====
// Top level of the contiguous first-fit block allocator.
`timescale 1ns / 1ps

// Contiguous first-fit allocator over NUM_BLOCKS blocks. A create request
// (tuser 0) takes the lowest run of block_count free blocks and records the
// name there; a delete request (tuser 1) frees the lowest-start file with a
// matching name. Each request gives one response. Requests enter a two-deep
// queue and are served one at a time by a sequencer that walks the block map
// or the file table one position per clock; a bad or oversized length skips
// the walk and is answered directly. No clearing pass is needed after reset.
module contiguous_block_allocator #(
  parameter int NUM_BLOCKS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // file_name[7:0], block_count[13:8]
  input  logic        s_axis_tuser,   // func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // status[2:0], start_block[7:3], run_length[13:8]
);
  import cba_pkg::*;

  logic push_valid;
  logic push_ready;
  req_t push_req;
  logic q_valid;
  logic q_pop;
  req_t q_req;
  res_t res;

  cba_front #(.NUM_BLOCKS(NUM_BLOCKS)) u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_req      (push_req)
  );

  cba_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_req   (push_req),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_req    (q_req)
  );

  cba_back #(.NUM_BLOCKS(NUM_BLOCKS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_req     (q_req),
    .q_pop     (q_pop),
    .res_valid (m_axis_tvalid),
    .res_ready (m_axis_tready),
    .res       (res)
  );

  assign m_axis_tdata = {2'b00, res.run_length, res.start_block, res.status};

endmodule

// ===== rtl/core/cba_front.sv =====
// Request intake: unpacks a request and classifies it for the back end.
`timescale 1ns / 1ps

module cba_front #(
  parameter int NUM_BLOCKS = 32
) (
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [15:0]          s_axis_tdata,   // file_name[7:0], block_count[13:8]
  input  logic                 s_axis_tuser,   // func
  output logic                 push_valid,
  input  logic                 push_ready,
  output cba_pkg::req_t        push_req
);
  import cba_pkg::*;

  logic [NAME_W-1:0] name;
  logic [LEN_W-1:0]  len;

  assign name          = s_axis_tdata[NAME_W-1:0];
  assign len           = s_axis_tdata[NAME_W+LEN_W-1:NAME_W];
  assign s_axis_tready = push_ready;
  assign push_valid    = s_axis_tvalid;

  always_comb begin
    push_req.file_name   = name;
    push_req.block_count = len;
    if (s_axis_tuser != FUNC_CREATE) begin
      push_req.kind = OP_DELETE;
    end else if (len == '0) begin
      push_req.kind = OP_BADLEN;
    end else if ({1'b0, len} > (LEN_W+1)'(NUM_BLOCKS)) begin
      push_req.kind = OP_NOSPACE;
    end else begin
      push_req.kind = OP_CREATE;
    end
  end

endmodule

// ===== rtl/core/cba_queue.sv =====
// Two-entry request queue between intake and sequencer.
`timescale 1ns / 1ps

module cba_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  cba_pkg::req_t push_req,
  output logic          pop_valid,
  input  logic          pop,
  output cba_pkg::req_t pop_req
);
  import cba_pkg::*;

  req_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_req    = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_req;
    end
  end

endmodule

// ===== rtl/core/cba_back.sv =====
// Allocation sequencer: block map, file table, first-fit walk and name search.
`timescale 1ns / 1ps

module cba_back #(
  parameter int NUM_BLOCKS = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  cba_pkg::req_t q_req,
  output logic          q_pop,
  output logic          res_valid,
  input  logic          res_ready,
  output cba_pkg::res_t res
);
  import cba_pkg::*;

  localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
  localparam int SUM_W = ((CNT_W > LEN_W) ? CNT_W : LEN_W) + 1;
  localparam int ENT_W = NAME_W + LEN_W;

  bk_state_t state, state_next;
  req_t      req;
  logic [CNT_W-1:0]    cnt, cnt_next;
  logic [LEN_W-1:0]    run, run_next;
  logic [IDX_W-1:0]    hit_idx, hit_idx_next;
  logic [LEN_W-1:0]    hit_len, hit_len_next;
  logic [STATUS_W-1:0] status, status_next;

  logic [NUM_BLOCKS-1:0] block_busy;
  logic [NUM_BLOCKS-1:0] entry_valid;
  logic [NUM_BLOCKS-1:0] run_mask;
  logic [ENT_W-1:0]      entry_mem [NUM_BLOCKS];

  logic [ENT_W-1:0]  rd_data;
  logic [IDX_W-1:0]  rd_idx;
  logic              rd_vld;
  logic              rd_en;
  logic [IDX_W-1:0]  cnt_idx;
  logic [SUM_W-1:0]  start_calc;
  logic [IDX_W+START_W-1:0] start_ext;
  logic              load_res;

  assign cnt_idx    = cnt[IDX_W-1:0];
  assign rd_en      = (state == BK_DEL) && (cnt != CNT_W'(NUM_BLOCKS));
  assign start_calc = SUM_W'(cnt) + SUM_W'(1) - SUM_W'(req.block_count);
  assign start_ext  = {START_W'(0), hit_idx};
  assign load_res   = (state == BK_REPLY) && (!res_valid || res_ready);

  always_comb begin
    for (int i = 0; i < NUM_BLOCKS; i++) begin
      run_mask[i] = (SUM_W'(i) >= SUM_W'(hit_idx)) &&
                    (SUM_W'(i) < SUM_W'(hit_idx) + SUM_W'(hit_len));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    run_next     = run;
    hit_idx_next = hit_idx;
    hit_len_next = hit_len;
    status_next  = status;
    q_pop        = 1'b0;
    case (state)
      BK_IDLE: begin
        q_pop = q_valid;
        if (q_valid) begin
          cnt_next     = '0;
          run_next     = '0;
          hit_idx_next = '0;
          hit_len_next = '0;
          case (q_req.kind)
            OP_CREATE: state_next = BK_ALLOC;
            OP_DELETE: state_next = BK_DEL;
            OP_BADLEN: begin
              status_next = ST_BADLEN;
              state_next  = BK_REPLY;
            end
            default: begin
              status_next = ST_NOSPACE;
              state_next  = BK_REPLY;
            end
          endcase
        end
      end
      BK_ALLOC: begin
        run_next = block_busy[cnt_idx] ? '0 : run + LEN_W'(1);
        if (!block_busy[cnt_idx] && (run + LEN_W'(1) == req.block_count)) begin
          hit_idx_next = start_calc[IDX_W-1:0];
          hit_len_next = req.block_count;
          state_next   = BK_MARK;
        end else if (cnt == CNT_W'(NUM_BLOCKS - 1)) begin
          status_next = ST_NOSPACE;
          state_next  = BK_REPLY;
        end else begin
          cnt_next = cnt + CNT_W'(1);
        end
      end
      BK_MARK: begin
        status_next = ST_CREATED;
        state_next  = BK_REPLY;
      end
      BK_DEL: begin
        if (rd_en) begin
          cnt_next = cnt + CNT_W'(1);
        end
        if (rd_vld && entry_valid[rd_idx] &&
            (rd_data[ENT_W-1:LEN_W] == req.file_name)) begin
          hit_idx_next = rd_idx;
          hit_len_next = rd_data[LEN_W-1:0];
          state_next   = BK_FREE;
        end else if (rd_vld && (rd_idx == IDX_W'(NUM_BLOCKS - 1))) begin
          status_next = ST_NOTFOUND;
          state_next  = BK_REPLY;
        end
      end
      BK_FREE: begin
        status_next = ST_DELETED;
        state_next  = BK_REPLY;
      end
      BK_REPLY: begin
        if (load_res) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    cnt     <= cnt_next;
    run     <= run_next;
    hit_idx <= hit_idx_next;
    hit_len <= hit_len_next;
    status  <= status_next;
    if (q_pop) begin
      req <= q_req;
    end
  end

  // block map and file table valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      block_busy  <= '0;
      entry_valid <= '0;
    end else if (state == BK_MARK) begin
      block_busy           <= block_busy | run_mask;
      entry_valid[hit_idx] <= 1'b1;
    end else if (state == BK_FREE) begin
      block_busy           <= block_busy & ~run_mask;
      entry_valid[hit_idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == BK_MARK) begin
      entry_mem[hit_idx] <= {req.file_name, req.block_count};
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= entry_mem[cnt_idx];
      rd_idx  <= cnt_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= rd_en;
    end
  end

  // result holding register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_res) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_res) begin
      res.status      <= status;
      res.start_block <= start_ext[START_W-1:0];
      res.run_length  <= hit_len;
    end
  end

  a_busy_only_on_update: assert property (@(posedge clk) disable iff (rst)
    !(state == BK_MARK || state == BK_FREE) |=> $stable(block_busy))
    else $error("block map changed outside mark/free");

  a_entry_start_busy: assert property (@(posedge clk) disable iff (rst)
    (entry_valid & ~block_busy) == '0)
    else $error("valid file entry starts on a free block");

  a_mark_sets_entry: assert property (@(posedge clk) disable iff (rst)
    state == BK_MARK |=> entry_valid[hit_idx])
    else $error("created run has no table entry");

  a_run_below_len: assert property (@(posedge clk) disable iff (rst)
    state == BK_ALLOC |-> run < req.block_count)
    else $error("free-run counter passed requested length");

endmodule

// ===== verif/tb_contiguous_block_allocator.sv =====
// Testbench for the contiguous block allocator: streamed requests checked by a scoreboard.
`timescale 1ns / 1ps

module tb_contiguous_block_allocator;
  import cba_pkg::*;

  localparam int NUM_BLOCKS = 32;
  localparam logic FUNC_DELETE = ~FUNC_CREATE;
  localparam int HOLD_CYCLES = 400;
  localparam int QUIET_LIMIT = 3000;
  localparam int ITEMS_PER_PHASE = 440;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;

  int src_idle_pct;
  int sink_stall_pct;
  int hold_left;
  bit hold_kick;
  int quiet_cycles;

  logic [7:0] name_pool [8] = '{8'h00, 8'hff, 8'h5a, 8'ha5, 8'h01, 8'h80, 8'h3c, 8'hc3};

  contiguous_block_allocator #(.NUM_BLOCKS(NUM_BLOCKS)) DUT (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  class alloc_scoreboard;
    bit         block_busy [NUM_BLOCKS];
    bit         file_live [NUM_BLOCKS];
    logic [7:0] file_name_at [NUM_BLOCKS];
    logic [5:0] file_len_at [NUM_BLOCKS];
    res_t       expected_responses [$];
    int         errors;

    // First-fit create or lowest-start delete, applied to the shadow map.
    function void note_request(logic func, logic [7:0] nm, logic [5:0] cnt);
      res_t r;
      bit   fits;
      bit   done;
      r.status = ST_NOTFOUND;
      r.start_block = '0;
      r.run_length = '0;
      done = 0;
      if (func == FUNC_CREATE) begin
        r.status = ST_NOSPACE;
        if (cnt == 0) begin
          r.status = ST_BADLEN;
        end else if (cnt <= NUM_BLOCKS) begin
          for (int s = 0; s + cnt <= NUM_BLOCKS && !done; s++) begin
            fits = 1;
            for (int k = 0; k < cnt; k++)
              if (block_busy[s+k]) fits = 0;
            if (fits) begin
              for (int k = 0; k < cnt; k++) block_busy[s+k] = 1;
              file_live[s] = 1;
              file_name_at[s] = nm;
              file_len_at[s] = cnt;
              r.status = ST_CREATED;
              r.start_block = s[START_W-1:0];
              r.run_length = cnt;
              done = 1;
            end
          end
        end
      end else begin
        for (int s = 0; s < NUM_BLOCKS && !done; s++) begin
          if (file_live[s] && file_name_at[s] == nm) begin
            for (int k = 0; k < file_len_at[s] && s + k < NUM_BLOCKS; k++)
              block_busy[s+k] = 0;
            file_live[s] = 0;
            r.status = ST_DELETED;
            r.start_block = s[START_W-1:0];
            r.run_length = file_len_at[s];
            done = 1;
          end
        end
      end
      expected_responses.push_back(r);
    endfunction

    function void check_response(logic [15:0] d);
      res_t want;
      if (expected_responses.size() == 0) begin
        $display("%0t: unexpected response %h", $time, d);
        errors++;
        return;
      end
      want = expected_responses.pop_front();
      if (d[2:0] !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, d[2:0]);
        errors++;
      end
      if (d[7:3] !== want.start_block) begin
        $display("%0t: start_block expected %0d actual %0d", $time, want.start_block, d[7:3]);
        errors++;
      end
      if (d[13:8] !== want.run_length) begin
        $display("%0t: run_length expected %0d actual %0d", $time, want.run_length, d[13:8]);
        errors++;
      end
    endfunction

    function logic [7:0] pick_live_name();
      logic [7:0] names [$];
      for (int s = 0; s < NUM_BLOCKS; s++)
        if (file_live[s]) names.push_back(file_name_at[s]);
      if (names.size() == 0) return 8'($urandom_range(0, 255));
      return names[$urandom_range(0, names.size() - 1)];
    endfunction

    function int busy_blocks();
      int n;
      n = 0;
      for (int s = 0; s < NUM_BLOCKS; s++) n += block_busy[s];
      return n;
    endfunction
  endclass

  alloc_scoreboard sb;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic send_request(input logic func, input logic [7:0] nm, input logic [5:0] cnt);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, cnt, nm};
    s_axis_tuser  <= func;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_request(func, nm, cnt);
  endtask

  task automatic random_request();
    int         roll;
    int         pick;
    logic [7:0] nm;
    logic [5:0] cnt;
    roll = $urandom_range(0, 99);
    nm = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 255))
                                     : name_pool[$urandom_range(0, 7)];
    pick = $urandom_range(0, 19);
    if (pick < 14)      cnt = 6'($urandom_range(1, 6));
    else if (pick < 19) cnt = 6'($urandom_range(7, NUM_BLOCKS));
    else                cnt = 6'($urandom_range(0, 63));
    // lean toward deletes when the map is nearly full
    if (sb.busy_blocks() > 24) roll += 30;
    if (roll < 50)
      send_request(FUNC_CREATE, nm, cnt);
    else if (roll < 90)
      send_request(FUNC_DELETE, sb.pick_live_name(), 6'($urandom_range(0, 63)));
    else if ($urandom_range(0, 1) == 0)
      send_request(FUNC_DELETE, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)));
    else
      send_request(FUNC_CREATE, nm, 6'($urandom_range(0, 63)));
  endtask

  always @(posedge clk) begin
    if (m_axis_tvalid && m_axis_tready) sb.check_response(m_axis_tdata);
    if (hold_kick) begin
      hold_left = HOLD_CYCLES;
      hold_kick = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("contiguous_block_allocator test failed");
          $finish;
        end
      end
    end
  end

  initial begin
    sb = new();
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    m_axis_tready = 1'b0;
    src_idle_pct = 0;
    sink_stall_pct = 0;
    hold_left = 0;
    hold_kick = 0;
    quiet_cycles = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_request(FUNC_CREATE, 8'h00, 6'd0);   // zero length
    send_request(FUNC_CREATE, 8'h11, 6'd33);  // longer than the map
    send_request(FUNC_CREATE, 8'h12, 6'd63);
    send_request(FUNC_CREATE, 8'hff, 6'd32);  // whole map
    send_request(FUNC_CREATE, 8'h01, 6'd1);   // map full
    send_request(FUNC_DELETE, 8'h02, 6'd0);   // unknown name
    send_request(FUNC_DELETE, 8'hff, 6'd0);
    send_request(FUNC_CREATE, 8'haa, 6'd3);
    send_request(FUNC_CREATE, 8'haa, 6'd5);   // duplicate name
    send_request(FUNC_CREATE, 8'h55, 6'd1);
    send_request(FUNC_DELETE, 8'haa, 6'd0);   // lowest start goes first
    send_request(FUNC_CREATE, 8'h33, 6'd2);   // refills the hole
    send_request(FUNC_CREATE, 8'h44, 6'd2);   // hole too small, skips ahead
    send_request(FUNC_CREATE, 8'h44, 6'd1);
    send_request(FUNC_DELETE, 8'haa, 6'd0);
    send_request(FUNC_DELETE, 8'haa, 6'd0);
    send_request(FUNC_CREATE, 8'h66, 6'd23);  // fragmented, no fit
    send_request(FUNC_CREATE, 8'h66, 6'd21);
    send_request(FUNC_DELETE, 8'h55, 6'd63);  // count ignored on delete
    send_request(FUNC_CREATE, 8'h7f, 6'd16);
    send_request(FUNC_CREATE, 8'h01, 6'd1);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          src_idle_pct = 0;
          sink_stall_pct = 0;
          hold_kick = 1;
        end
        1: begin
          src_idle_pct = 84;
          sink_stall_pct = 0;
        end
        2: begin
          src_idle_pct = 0;
          sink_stall_pct = 84;
        end
        default: begin
          src_idle_pct = 20;
          sink_stall_pct = 20;
        end
      endcase
      repeat (ITEMS_PER_PHASE) random_request();
    end

    s_axis_tvalid <= 1'b0;
    while (sb.expected_responses.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (sb.errors == 0)
      $display("contiguous_block_allocator test passed");
    else
      $display("contiguous_block_allocator test failed");
    $finish;
  end

endmodule
